// ----- rtl/core/gf2is_pkg.sv -----
// Shared types and constants of the GF(2) irreducible-polynomial sieve.
package gf2is_pkg;

   // Request selector codes
   localparam logic CMD_SIEVE = 1'b0;
   localparam logic CMD_NEXT  = 1'b1;

   // Fixed field widths of the request and response
   localparam int START_BITS    = 16;
   localparam int POLY_OUT_BITS = 16;
   localparam logic [POLY_OUT_BITS-1:0] POLY_OUT_MAX = 16'hFFFF;

   typedef enum logic [4:0] {
      S_INIT,
      S_IDLE,
      S_FILL,
      S_P_NEXT,
      S_P_SPLIT,
      S_P_READ,
      S_P_TEST,
      S_C_SPLIT,
      S_C_READ,
      S_C_WRITE,
      S_C_WAIT,
      S_C_CHK,
      S_N_CHK,
      S_N_SPLIT,
      S_N_READ,
      S_N_TEST,
      S_RESP_NONE,
      S_RESP_HIT
   } state_type;

   // Source of the bit address fed to the word/offset splitter
   typedef enum logic [1:0] {
      SRC_P,
      SRC_PROD,
      SRC_T
   } split_src_type;

   typedef struct packed {
      logic          fill_we;
      logic          fill_sieve;
      split_src_type split_src;
      logic          split_load;
      logic          clr_we;
      logic          p_init;
      logic          p_adv;
      logic          q_adv;
      logic          scan_adv;
      logic          start_load;
      logic          res_load;
      logic          res_hit;
   } dp_cmd_type;

   typedef struct packed {
      logic fill_last;
      logic p_over;
      logic q_over;
      logic bit_set;
      logic prod_big;
      logic t_over;
      logic entry_nz;
      logic scan_last;
   } dp_sts_type;

endpackage

// ----- rtl/core/gf2_irreducible_sieve_top.sv -----
// Top level of the GF(2) irreducible-polynomial sieve: controller plus datapath.
//
// The block holds one bit for each GF(2) polynomial below 2^POLY_BITS in a memory of
// ceil(2^POLY_BITS / WORD_BITS) words. After reset a fill pass writes every word, one a
// cycle; no request is taken until it ends. A sieve request (selector 0) refills the map
// with polynomials 0 and 1 cleared, then tests each candidate p and clears each
// carry-less multiple p*q through a read-modify-write of its bitmap word; it answers
// found = 0. A next request (selector 1) returns the smallest polynomial still marked
// above start_value: it splits start_value + 1 into word and offset, then reads and
// tests one word after another until a marked bit or the last word, and loads the
// response. If start_value + 1 is past the top of the map, it answers found = 0.
// One request is worked on at a time; a new one is taken while the previous response
// still waits in the output register.
module gf2_irreducible_sieve_top
   import gf2is_pkg::*;
#(
   parameter int POLY_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [START_BITS-1:0]    req_tdata,  // [15:0] start_value
   input  logic [0:0]               req_tuser,  // [0] command
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [POLY_OUT_BITS-1:0] rsp_tdata,  // [15:0] poly_value
   output logic [0:0]               rsp_tuser   // [0] found
);

   dp_cmd_type cmd;
   dp_sts_type sts;

   // Sequencer
   gf2is_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_sel    (req_tuser[0]),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Bitmap and arithmetic
   gf2is_dpath #(
      .POLY_BITS (POLY_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_start (req_tdata),
      .sts       (sts),
      .rsp_found (rsp_tuser[0]),
      .rsp_poly  (rsp_tdata)
   );

endmodule

// ----- rtl/core/gf2is_dpath.sv -----
// Datapath of the sieve: bitmap memory, carry-less multiplier, address splitter, scanner.
module gf2is_dpath
   import gf2is_pkg::*;
#(
   parameter int POLY_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  dp_cmd_type               cmd,
   input  logic [START_BITS-1:0]    req_start,
   output dp_sts_type               sts,
   output logic                     rsp_found,
   output logic [POLY_OUT_BITS-1:0] rsp_poly
);

   localparam longint unsigned POLY_LIMIT = 64'd1 << POLY_BITS;
   localparam longint unsigned MAP_WORDS  =
      (POLY_LIMIT + longint'(WORD_BITS) - 64'd1) / longint'(WORD_BITS);
   localparam int IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int OFF_W  = $clog2(WORD_BITS);
   localparam int SHIFT  = POLY_BITS + OFF_W;
   localparam int MUL_W  = (2 * POLY_BITS + 1 > SHIFT + IDX_W) ? 2 * POLY_BITS + 1
                                                               : SHIFT + IDX_W;
   localparam int PROD_W = 2 * POLY_BITS + 2;
   localparam int RES_W  = IDX_W + OFF_W + 1;
   localparam int T_W    = START_BITS + 1;

   // Rounded-up reciprocal of the word size, scaled by 2^SHIFT, for the address split
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(WORD_BITS) - 64'd1) / 64'(WORD_BITS);
   localparam logic [POLY_BITS:0] RECIP = RECIP_FULL[POLY_BITS:0];

   localparam logic [WORD_BITS-1:0] WORD_ONES  = '1;
   localparam logic [WORD_BITS-1:0] WORD_LOW_CLR = WORD_ONES << 2;
   localparam logic [WORD_BITS-1:0] WORD_ONE   = WORD_BITS'(1);
   localparam logic [IDX_W-1:0]     IDX_LAST   = IDX_W'(MAP_WORDS - 64'd1);

   function automatic logic [PROD_W-1:0] clmul(input logic [POLY_BITS:0] a,
                                               input logic [POLY_BITS:0] b);
      logic [PROD_W-1:0] r;
      r = '0;
      for (int i = 0; i <= POLY_BITS; i++) begin
         if (b[i]) begin
            r = r ^ (PROD_W'(a) << i);
         end
      end
      return r;
   endfunction

   logic [WORD_BITS-1:0]     bitmap_ff [MAP_WORDS];
   logic [WORD_BITS-1:0]     rdata_ff;
   logic [IDX_W-1:0]         fill_ff;
   logic [IDX_W-1:0]         fill_in;
   logic [POLY_BITS:0]       p_ff;
   logic [POLY_BITS:0]       p_in;
   logic [POLY_BITS:0]       q_ff;
   logic [POLY_BITS:0]       q_in;
   logic [PROD_W-1:0]        prod_ff;
   logic [START_BITS-1:0]    start_ff;
   logic [T_W-1:0]           t_val;
   logic [POLY_BITS-1:0]     x_in;
   logic [POLY_BITS-1:0]     x_ff;
   logic [MUL_W-1:0]         mul_in;
   logic [MUL_W-1:0]         mul_ff;
   logic [IDX_W-1:0]         split_idx;
   logic [POLY_BITS-1:0]     split_base;
   logic [IDX_W-1:0]         idx_ff;
   logic [OFF_W-1:0]         off_ff;
   logic [WORD_BITS-1:0]     entry;
   logic [WORD_BITS-1:0]     low_bit;
   logic [OFF_W-1:0]         pos_in;
   logic [OFF_W-1:0]         pos_ff;
   logic [RES_W-1:0]         hit_pos;
   logic                     hit_ok;
   logic [WORD_BITS-1:0]     fill_word;
   logic                     found_ff;
   logic [POLY_OUT_BITS-1:0] poly_ff;

   // Fill counter: wraps to zero after the last word
   assign fill_in = sts.fill_last ? '0 : fill_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.fill_we) begin
         fill_ff <= fill_in;
      end
   end

   // Word 0 loses polynomials 0 and 1 when the sieve fills
   assign fill_word = (cmd.fill_sieve && (fill_ff == '0)) ? WORD_LOW_CLR : WORD_ONES;

   // Bitmap write port: fill sweep or clearing of one multiple
   always_ff @(posedge clock) begin
      if (cmd.fill_we) begin
         bitmap_ff[fill_ff] <= fill_word;
      end else if (cmd.clr_we) begin
         bitmap_ff[idx_ff] <= rdata_ff & ~(WORD_ONE << off_ff);
      end
   end

   // Bitmap read port, registered
   always_ff @(posedge clock) begin
      rdata_ff <= bitmap_ff[idx_ff];
   end

   // Candidate p and multiplier q
   always_comb begin
      p_in = p_ff;
      q_in = q_ff;
      if (cmd.p_init) begin
         p_in = (POLY_BITS + 1)'(2);
         q_in = (POLY_BITS + 1)'(2);
      end else if (cmd.p_adv) begin
         p_in = p_ff + 1'b1;
         q_in = p_ff + 1'b1;
      end else if (cmd.q_adv) begin
         q_in = q_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      q_ff    <= q_in;
      prod_ff <= clmul(p_ff, q_ff);
   end

   // Hold the start value of a next request
   always_ff @(posedge clock) begin
      if (cmd.start_load) begin
         start_ff <= req_start;
      end
   end

   assign t_val = T_W'(start_ff) + T_W'(1);

   // Splitter stage 1: pick the bit address and multiply by the reciprocal
   always_comb begin
      case (cmd.split_src)
         SRC_P:    x_in = p_ff[POLY_BITS-1:0];
         SRC_PROD: x_in = prod_ff[POLY_BITS-1:0];
         SRC_T:    x_in = POLY_BITS'(t_val);
         default:  x_in = '0;
      endcase
      mul_in = MUL_W'(x_in) * MUL_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      mul_ff <= mul_in;
   end

   // Splitter stage 2: word index and offset in the word
   assign split_idx  = mul_ff[SHIFT +: IDX_W];
   assign split_base = POLY_BITS'(RES_W'(split_idx) * RES_W'(WORD_BITS));

   always_ff @(posedge clock) begin
      if (cmd.split_load) begin
         idx_ff <= split_idx;
         off_ff <= OFF_W'(x_ff - split_base);
      end else if (cmd.scan_adv) begin
         idx_ff <= idx_ff + 1'b1;
         off_ff <= '0;
      end
   end

   // Lowest set bit at or above the offset
   always_comb begin
      entry   = rdata_ff & (WORD_ONES << off_ff);
      low_bit = entry & (~entry + 1'b1);
      pos_in  = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (low_bit[i]) begin
            pos_in = pos_in | OFF_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
   end

   // Polynomial found by the scan and its range check
   assign hit_pos = RES_W'(idx_ff) * RES_W'(WORD_BITS) + RES_W'(pos_ff);
   assign hit_ok  = (64'(hit_pos) < POLY_LIMIT) && (64'(hit_pos) <= 64'(POLY_OUT_MAX));

   // Response register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         if (cmd.res_hit && hit_ok) begin
            found_ff <= 1'b1;
            poly_ff  <= POLY_OUT_BITS'(hit_pos);
         end else begin
            found_ff <= 1'b0;
            poly_ff  <= '0;
         end
      end
   end

   assign rsp_found = found_ff;
   assign rsp_poly  = poly_ff;

   // Status to the controller
   always_comb begin
      sts.fill_last = (fill_ff == IDX_LAST);
      sts.p_over    = p_ff[POLY_BITS];
      sts.q_over    = q_ff[POLY_BITS];
      sts.bit_set   = rdata_ff[off_ff];
      sts.prod_big  = |prod_ff[PROD_W-1:POLY_BITS];
      sts.t_over    = (64'(t_val) >= POLY_LIMIT);
      sts.entry_nz  = |entry;
      sts.scan_last = (idx_ff == IDX_LAST);
   end

endmodule

// ----- rtl/core/gf2is_ctrl.sv -----
// Controller state machine of the sieve: sequences fill, sieve walk, scan and response.
module gf2is_ctrl
   import gf2is_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_sel,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd,
   input  dp_sts_type sts
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // State and response-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.split_src  = SRC_P;
      req_tready     = 1'b0;
      case (state_ff)
         S_INIT: begin
            cmd.fill_we = 1'b1;
            if (sts.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start_load = 1'b1;
               case (req_sel)
                  CMD_SIEVE: state_in = S_FILL;
                  CMD_NEXT:  state_in = S_N_CHK;
                  default:   state_in = S_N_CHK;
               endcase
            end
         end
         S_FILL: begin
            cmd.fill_we    = 1'b1;
            cmd.fill_sieve = 1'b1;
            if (sts.fill_last) begin
               cmd.p_init = 1'b1;
               state_in   = S_P_NEXT;
            end
         end
         S_P_NEXT: begin
            cmd.split_src = SRC_P;
            state_in = sts.p_over ? S_RESP_NONE : S_P_SPLIT;
         end
         S_P_SPLIT: begin
            cmd.split_load = 1'b1;
            state_in       = S_P_READ;
         end
         S_P_READ: begin
            state_in = S_P_TEST;
         end
         S_P_TEST: begin
            if (!sts.bit_set) begin
               cmd.p_adv = 1'b1;
               state_in  = S_P_NEXT;
            end else if (sts.prod_big) begin
               state_in = S_RESP_NONE;
            end else begin
               cmd.split_src = SRC_PROD;
               state_in      = S_C_SPLIT;
            end
         end
         S_C_SPLIT: begin
            cmd.split_load = 1'b1;
            state_in       = S_C_READ;
         end
         S_C_READ: begin
            state_in = S_C_WRITE;
         end
         S_C_WRITE: begin
            cmd.clr_we = 1'b1;
            cmd.q_adv  = 1'b1;
            state_in   = S_C_WAIT;
         end
         S_C_WAIT: begin
            state_in = S_C_CHK;
         end
         S_C_CHK: begin
            if (sts.q_over || sts.prod_big) begin
               cmd.p_adv = 1'b1;
               state_in  = S_P_NEXT;
            end else begin
               cmd.split_src = SRC_PROD;
               state_in      = S_C_SPLIT;
            end
         end
         S_N_CHK: begin
            cmd.split_src = SRC_T;
            state_in = sts.t_over ? S_RESP_NONE : S_N_SPLIT;
         end
         S_N_SPLIT: begin
            cmd.split_load = 1'b1;
            state_in       = S_N_READ;
         end
         S_N_READ: begin
            state_in = S_N_TEST;
         end
         S_N_TEST: begin
            if (sts.entry_nz) begin
               state_in = S_RESP_HIT;
            end else if (sts.scan_last) begin
               state_in = S_RESP_NONE;
            end else begin
               cmd.scan_adv = 1'b1;
               state_in     = S_N_READ;
            end
         end
         S_RESP_NONE: begin
            if (out_free) begin
               cmd.res_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RESP_HIT: begin
            if (out_free) begin
               cmd.res_load = 1'b1;
               cmd.res_hit  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Raise valid on a load, drop it once the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.res_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.res_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response loaded over one not yet taken");

   a_rsp_rise: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.res_load))
      else $error("response valid raised without a load");

   a_accept_leave: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == S_FILL || state_ff == S_N_CHK))
      else $error("accepted request did not start work");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.fill_we && cmd.clr_we))
      else $error("fill and clear write in the same cycle");

endmodule
